[rtl/sre_pkg.sv]
// Shared constants and types of the sprite run-length encoder.
package sre_pkg;

    localparam int MAX_RUN_LENGTH = 255;
    localparam int MAX_DIMENSION  = 4096;
    localparam int COORD_W        = 12;
    localparam int DIM_W          = 13;
    localparam int LEN_W          = 8;
    localparam int COLOR_W        = 32;
    localparam int SRE_QUEUE_DEPTH = 4;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MASK   = 2'd2;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_RUN   = 1'b1
    } elem_kind_t;

    // Configuration handed to the front end
    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COLOR_W-1:0] mask;
    } sre_cfg_t;

    // One queue entry: every element that one pixel causes.
    // present[0]: close of the previous run, present[1]: start element,
    // present[2]: run completed by the pixel itself.
    typedef struct packed {
        logic [2:0]         present;
        logic [COLOR_W-1:0] close_color;
        logic [LEN_W-1:0]   close_len;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COLOR_W-1:0] done_color;
        logic [LEN_W-1:0]   done_len;
    } sre_entry_t;

endpackage

[rtl/sprite_run_length_encoder.sv]
// Sprite run-length encoder: top level with configuration registers.
// Pixels enter one per clock in raster order whenever the four-entry item
// queue between the front and back ends has room; each pixel yields zero to
// three elements (close of the previous run, start position, completed run),
// and the output register sends one element per clock while out_stall is
// low, so the sustained rate is one pixel per clock for pixels that cause at
// most one element and one clock per element otherwise. The user must write
// configuration (image_width at 0x0, image_height at 0x4, color_mask at 0x8)
// over APB only while no pixel is in flight; the block does not enforce it.
module sprite_run_length_encoder
    import sre_pkg::*;
#(
    parameter int QUEUE_DEPTH = SRE_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // pixel channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COLOR_W-1:0] pixel_value,
    // element channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               element_kind,
    output logic [COORD_W-1:0] pos_x,
    output logic [COORD_W-1:0] pos_y,
    output logic [COLOR_W-1:0] run_color,
    output logic [LEN_W-1:0]   run_length,
    output logic               last_in_item
);

    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [COLOR_W-1:0] mask_reg;
    logic               cfg_write;
    sre_cfg_t           cfg;

    logic               push, pop, queue_full, head_valid;
    sre_entry_t         push_entry, head_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(64);
            height_reg <= DIM_W'(64);
            mask_reg   <= 32'h00FF_FFFF;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_MASK:   mask_reg   <= pwdata;
                default:    ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_reg};
            REG_MASK:   prdata = mask_reg;
            default:    prdata = '0;
        endcase
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.mask   = mask_reg;

    sre_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .pixel_value (pixel_value),
        .queue_full  (queue_full),
        .in_stall    (in_stall),
        .push        (push),
        .push_entry  (push_entry)
    );

    sre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    sre_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .element_kind (element_kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .run_color    (run_color),
        .run_length   (run_length),
        .last_in_item (last_in_item)
    );

endmodule

[rtl/sre_front.sv]
// Front end: accepts pixels, tracks position and runs, classifies elements.
module sre_front
    import sre_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sre_cfg_t           cfg,
    input  logic               in_valid,
    input  logic [COLOR_W-1:0] pixel_value,
    input  logic               queue_full,
    output logic               in_stall,
    output logic               push,
    output sre_entry_t         push_entry
);

    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COLOR_W-1:0] key_reg, key_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [DIM_W-1:0]   ex_reg, ex_next;
    logic [COORD_W-1:0] ey_reg, ey_next;
    logic               ev_reg, ev_next;

    logic               accept;
    logic [COLOR_W-1:0] masked;
    logic [DIM_W-1:0]   w_clamp, h_clamp;
    logic [DIM_W-1:0]   col_plus, row_plus;
    logic               row_end, frame_end, frame_start;
    logic [COLOR_W-1:0] key_now;
    logic               ev_now;
    logic               close1, opaque, start_el, close2;
    logic [DIM_W-1:0]   ex1;
    logic [LEN_W-1:0]   len1, len2;
    logic [COLOR_W-1:0] color2;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign masked   = pixel_value & cfg.mask;

    // Clamp the frame size to 1..MAX_DIMENSION
    always_comb
    begin
        if (cfg.width == '0)
            w_clamp = DIM_W'(1);
        else if (cfg.width > DIM_W'(MAX_DIMENSION))
            w_clamp = DIM_W'(MAX_DIMENSION);
        else
            w_clamp = cfg.width;
        if (cfg.height == '0)
            h_clamp = DIM_W'(1);
        else if (cfg.height > DIM_W'(MAX_DIMENSION))
            h_clamp = DIM_W'(MAX_DIMENSION);
        else
            h_clamp = cfg.height;
    end

    // Position of this pixel within the frame
    assign col_plus    = {1'b0, col_reg} + DIM_W'(1);
    assign row_plus    = {1'b0, row_reg} + DIM_W'(1);
    assign row_end     = col_plus >= w_clamp;
    assign frame_end   = row_plus >= h_clamp;
    assign frame_start = (col_reg == '0) && (row_reg == '0);

    // Latch the key on the first pixel of a frame
    assign key_now = frame_start ? masked : key_reg;
    assign ev_now  = frame_start ? 1'b0 : ev_reg;

    // Close the open run on a color change or a transparent pixel
    assign close1 = (len_reg != '0) && ((masked != color_reg) || (masked == key_now));
    assign ex1    = close1 ? (ex_reg + {{(DIM_W-LEN_W){1'b0}}, len_reg}) : ex_reg;
    assign len1   = close1 ? '0 : len_reg;
    assign opaque = masked != key_now;

    // Start element where the new run does not continue the last one
    assign start_el = opaque && (len1 == '0) &&
                      !(ev_now && (ex1 == {1'b0, col_reg}) && (ey_reg == row_reg));

    // Grow or open the run, then close it at full length or row end
    always_comb
    begin
        if (opaque && (len1 == '0))
        begin
            color2 = masked;
            len2   = LEN_W'(1);
        end
        else if (opaque)
        begin
            color2 = color_reg;
            len2   = len1 + LEN_W'(1);
        end
        else
        begin
            color2 = color_reg;
            len2   = len1;
        end
    end

    assign close2 = opaque && ((len2 >= LEN_W'(MAX_RUN_LENGTH)) || row_end);

    // Next state of the tracking registers
    always_comb
    begin
        key_next   = key_now;
        color_next = color2;
        len_next   = close2 ? '0 : len2;
        ey_next    = start_el ? row_reg : ey_reg;
        ev_next    = start_el ? 1'b1 : ev_now;
        if (close2)
            ex_next = (start_el ? {1'b0, col_reg} : ex1) + {{(DIM_W-LEN_W){1'b0}}, len2};
        else
            ex_next = start_el ? {1'b0, col_reg} : ex1;
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + COORD_W'(1);
        end
        else
        begin
            col_next = col_reg + COORD_W'(1);
            row_next = row_reg;
        end
    end

    // Build the queue entry
    always_comb
    begin
        push_entry.present     = {close2, start_el, close1};
        push_entry.close_color = color_reg;
        push_entry.close_len   = len_reg;
        push_entry.start_x     = col_reg;
        push_entry.start_y     = row_reg;
        push_entry.done_color  = color2;
        push_entry.done_len    = len2;
    end

    assign push = accept && (close1 || start_el || close2);

    // Advance the state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            key_reg   <= '0;
            color_reg <= '0;
            len_reg   <= '0;
            ex_reg    <= '0;
            ey_reg    <= '0;
            ev_reg    <= 1'b0;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            key_reg   <= key_next;
            color_reg <= color_next;
            len_reg   <= len_next;
            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
            ev_reg    <= ev_next;
        end
    end

    // A run that reaches full length is always closed at once
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg != LEN_W'(MAX_RUN_LENGTH))
        else $error("open run held at full length");

endmodule

[rtl/sre_queue.sv]
// Short queue of classified items between the front and back ends.
module sre_queue
    import sre_pkg::*;
#(
    parameter int DEPTH = SRE_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  sre_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output sre_entry_t head_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sre_entry_t         store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = store_reg[rd_ptr_reg];

    // Write the entry at the tail
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("pop from empty queue");

endmodule

[rtl/sre_back.sv]
// Back end: serializes the elements of each queue entry into the output register.
module sre_back
    import sre_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  sre_entry_t         head_entry,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               element_kind,
    output logic [COORD_W-1:0] pos_x,
    output logic [COORD_W-1:0] pos_y,
    output logic [COLOR_W-1:0] run_color,
    output logic [LEN_W-1:0]   run_length,
    output logic               last_in_item
);

    logic [2:0]         done_reg, done_next;
    logic               out_valid_reg;
    elem_kind_t         kind_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               last_reg;

    logic [2:0]         remaining, sel;
    logic               load, last;

    assign remaining = head_entry.present & ~done_reg;
    assign load      = head_valid && (!out_valid_reg || !out_stall);

    // Pick the earliest element still pending in the head entry
    always_comb
    begin
        priority if (remaining[0])
            sel = 3'b001;
        else if (remaining[1])
            sel = 3'b010;
        else
            sel = 3'b100;
    end

    assign last      = (remaining & ~sel) == 3'b000;
    assign pop       = load && last;
    assign done_next = pop ? 3'b000 : (load ? (done_reg | sel) : done_reg);

    // Hold the output register until taken; load the next element
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= last;
            if (sel[1])
            begin
                kind_reg  <= KIND_START;
                x_reg     <= head_entry.start_x;
                y_reg     <= head_entry.start_y;
                color_reg <= '0;
                len_reg   <= '0;
            end
            else
            begin
                kind_reg  <= KIND_RUN;
                x_reg     <= '0;
                y_reg     <= '0;
                color_reg <= sel[0] ? head_entry.close_color : head_entry.done_color;
                len_reg   <= sel[0] ? head_entry.close_len : head_entry.done_len;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign element_kind = kind_reg;
    assign pos_x        = x_reg;
    assign pos_y        = y_reg;
    assign run_color    = color_reg;
    assign run_length   = len_reg;
    assign last_in_item = last_reg;

    // Every run element carries a nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_RUN)) |-> (len_reg != '0))
        else $error("run element with zero length");

    // A loaded entry always has an element left to send
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (remaining != 3'b000))
        else $error("queue head with nothing pending");

endmodule
